/* hdl/gbn_pkg.sv */
// Shared types and constants for the Go-Back-N packet receiver.
// The register stage, the checksum unit, the acknowledgement unit and the top level use it.
// No dependencies.
`default_nettype none

package gbn_pkg;

  localparam int MAX_BYTES_DEF = 1024;

  localparam int BYTE_W = 8;
  localparam int SUM_W  = 16;
  localparam int SEQ_W  = 32;
  localparam int SIZE_W = 11;
  localparam int ID_W   = 32;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    logic              last_item;
    logic [SEQ_W-1:0]  seq_number;
    logic [SIZE_W-1:0] data_size;
    logic [SUM_W-1:0]  rx_checksum;
    logic [ID_W-1:0]   packet_id;
  } item_t;

endpackage

`default_nettype wire

/* hdl/go_back_n_packet_receiver.sv */
// Go-Back-N packet receiver with Internet checksum, top level.
// A last item's acknowledgement passes the input register, then the result register.
// Throughput: one item per cycle; only a last item waits in the input register, and only
// while the previous acknowledgement is held by out_stall.
// Reset (rst, synchronous): clears the checksum state, the byte count, the
// expected sequence number and both valid flags. Depends on gbn_pkg and submodules.
`default_nettype none

module go_back_n_packet_receiver #(
  parameter int MAX_BYTES = gbn_pkg::MAX_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [gbn_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                     byte_valid,
  input  wire logic                     last_item,
  input  wire logic [gbn_pkg::SEQ_W-1:0]  seq_number,
  input  wire logic [gbn_pkg::SIZE_W-1:0] data_size,
  input  wire logic [gbn_pkg::SUM_W-1:0]  rx_checksum,
  input  wire logic [gbn_pkg::ID_W-1:0]   packet_id,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [gbn_pkg::SEQ_W-1:0]     ack_number,
  output logic                          corrupt,
  output logic                          in_order,
  output logic [gbn_pkg::ID_W-1:0]      ack_packet_id
);
  import gbn_pkg::*;

  item_t            item_in;
  item_t            item;
  logic             item_valid;
  logic             load;
  logic             step;
  logic             out_free;
  logic [SUM_W-1:0] computed;

  assign item_in = '{data_byte:   data_byte,
                     byte_valid:  byte_valid,
                     last_item:   last_item,
                     seq_number:  seq_number,
                     data_size:   data_size,
                     rx_checksum: rx_checksum,
                     packet_id:   packet_id};

  // Items that close no packet never wait for the result register.
  assign out_free = !out_valid || !out_stall;
  assign step     = item_valid && (!item.last_item || out_free);
  assign in_stall = item_valid && !step;
  assign load     = in_valid && !in_stall;

  gbn_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .advance (step),
    .item_in (item_in),
    .valid   (item_valid),
    .item    (item)
  );

  gbn_csum #(.MAX_BYTES(MAX_BYTES)) u_csum (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (item),
    .computed (computed)
  );

  gbn_ack #(.MAX_BYTES(MAX_BYTES)) u_ack (
    .clk           (clk),
    .rst           (rst),
    .fire          (step && item.last_item),
    .item          (item),
    .computed      (computed),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .ack_number    (ack_number),
    .corrupt       (corrupt),
    .in_order      (in_order),
    .ack_packet_id (ack_packet_id)
  );

endmodule

`default_nettype wire

/* hdl/gbn_in_reg.sv */
// Input register stage of the Go-Back-N receiver: holds one accepted item.
// Depends on gbn_pkg.
`default_nettype none

module gbn_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire logic          advance,
  input  wire gbn_pkg::item_t item_in,
  output logic               valid,
  output gbn_pkg::item_t     item
);
  import gbn_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

/* hdl/gbn_csum.sv */
// Checksum unit: pairs payload bytes into big-endian words and keeps the
// ones'-complement running sum and the per-packet byte count. Depends on gbn_pkg.
`default_nettype none

module gbn_csum #(
  parameter int MAX_BYTES = gbn_pkg::MAX_BYTES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    step,
  input  wire gbn_pkg::item_t          item,
  output logic [gbn_pkg::SUM_W-1:0]    computed
);
  import gbn_pkg::*;

  localparam int CW = $clog2(MAX_BYTES + 1);

  logic [SUM_W-1:0]  running_sum;
  logic              low_half_next;
  logic [BYTE_W-1:0] held_high_byte;
  logic [CW-1:0]     byte_count;

  logic              take;
  logic [SUM_W-1:0]  word;
  logic [SUM_W:0]    raw_sum;
  logic [SUM_W-1:0]  new_sum;

  // One adder serves both the pairing of a completed word and the padding
  // of an odd byte at the end of a packet.
  always_comb begin
    take = item.byte_valid && (byte_count < CW'(MAX_BYTES));
    if (low_half_next) begin
      word = {held_high_byte, (take ? item.data_byte : {BYTE_W{1'b0}})};
    end else if (take && item.last_item) begin
      word = {item.data_byte, {BYTE_W{1'b0}}};
    end else begin
      word = '0;
    end
    raw_sum  = {1'b0, running_sum} + {1'b0, word};
    new_sum  = raw_sum[SUM_W-1:0] + SUM_W'(raw_sum[SUM_W]);
    computed = ~new_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      low_half_next  <= 1'b0;
      held_high_byte <= '0;
      byte_count     <= '0;
    end else if (step) begin
      if (item.last_item) begin
        running_sum    <= '0;
        low_half_next  <= 1'b0;
        held_high_byte <= '0;
        byte_count     <= '0;
      end else if (take) begin
        byte_count <= CW'(byte_count + 1'b1);
        if (low_half_next) begin
          running_sum    <= new_sum;
          low_half_next  <= 1'b0;
          held_high_byte <= '0;
        end else begin
          held_high_byte <= item.data_byte;
          low_half_next  <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/gbn_ack.sv */
// Acknowledgement unit: checks the checksum, tracks the expected sequence
// number and holds the result register. Depends on gbn_pkg.
`default_nettype none

module gbn_ack #(
  parameter int MAX_BYTES = gbn_pkg::MAX_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire gbn_pkg::item_t        item,
  input  wire logic [gbn_pkg::SUM_W-1:0] computed,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [gbn_pkg::SEQ_W-1:0]  ack_number,
  output logic                       corrupt,
  output logic                       in_order,
  output logic [gbn_pkg::ID_W-1:0]   ack_packet_id
);
  import gbn_pkg::*;

  localparam int EW = 17;

  logic [SEQ_W-1:0] expected_seq;
  logic [SEQ_W-1:0] expected_seq_next;
  logic [EW-1:0]    size_ext;
  logic [EW-1:0]    size_sat;
  logic             bad;
  logic             match;

  always_comb begin
    size_ext = EW'(item.data_size);
    size_sat = (size_ext > EW'(MAX_BYTES)) ? EW'(MAX_BYTES) : size_ext;
    bad      = computed != item.rx_checksum;
    match    = !bad && (item.seq_number == expected_seq);
    expected_seq_next = match ? SEQ_W'(expected_seq + SEQ_W'(size_sat)) : expected_seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      expected_seq <= '0;
    end else if (fire) begin
      out_valid    <= 1'b1;
      expected_seq <= expected_seq_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ack_number    <= expected_seq_next;
      corrupt       <= bad;
      in_order      <= match;
      ack_packet_id <= item.packet_id;
    end
  end

endmodule

`default_nettype wire

/* hdl/gbn_checker.sv */
// Port-level checks for the Go-Back-N receiver, bound to the top level.
// Depends on go_back_n_packet_receiver.
`default_nettype none

module gbn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] ack_number,
  input wire logic        corrupt,
  input wire logic        in_order,
  input wire logic [31:0] ack_packet_id
);

  // The input side only waits when a finished acknowledgement is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the result register could drain");

  // A packet that fails the checksum is never reported as in order.
  a_order_intact: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(in_order && corrupt))
    else $error("in_order reported for a corrupt packet");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result still valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(ack_number) && $stable(corrupt)
                                  && $stable(in_order) && $stable(ack_packet_id)))
    else $error("stalled acknowledgement changed or was dropped");

endmodule

bind go_back_n_packet_receiver gbn_checker u_gbn_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .ack_number    (ack_number),
  .corrupt       (corrupt),
  .in_order      (in_order),
  .ack_packet_id (ack_packet_id)
);

`default_nettype wire
